// File: src/space_vector_pwm_modulator_defines.svh
// assertion macros for the space vector pwm modulator
`ifndef SPACE_VECTOR_PWM_MODULATOR_DEFINES_SVH
`define SPACE_VECTOR_PWM_MODULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SVPWM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/svpwm_pkg.sv
// shared constants, types and sine table for the space vector pwm modulator
package svpwm_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int SINE_VAL_W = 15;
  localparam int SVPWM_LATENCY = 8;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint SINE_X_DIV = 2 * SINE_TABLE_ENTRIES;
  localparam longint Q14_ONE = 64'sd16384;

  typedef logic [SINE_VAL_W-1:0] sine_tab_t [SINE_TABLE_ENTRIES+1];

  typedef struct packed {
    logic               valid;
    logic signed [15:0] sin;
    logic signed [15:0] cos;
    logic signed [15:0] d;
    logic signed [15:0] q;
  } svpwm_trig_t;

  typedef struct packed {
    logic               valid;
    logic signed [47:0] ua;
    logic signed [47:0] ub;
    logic signed [47:0] uc;
  } svpwm_phase_t;

  // quarter-wave sine, q1.14, taylor series in q30
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    v;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (PI_Q30 * longint'(k)) / SINE_X_DIV;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;   sum = sum - term;
      term = ((term * x2) >>> 30) / 20;  sum = sum + term;
      term = ((term * x2) >>> 30) / 42;  sum = sum - term;
      term = ((term * x2) >>> 30) / 72;  sum = sum + term;
      term = ((term * x2) >>> 30) / 110; sum = sum - term;
      term = ((term * x2) >>> 30) / 156; sum = sum + term;
      term = ((term * x2) >>> 30) / 210; sum = sum - term;
      term = ((term * x2) >>> 30) / 272; sum = sum + term;
      term = ((term * x2) >>> 30) / 342; sum = sum - term;
      term = ((term * x2) >>> 30) / 420; sum = sum + term;
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd32768) >>> 16;
      if (v > Q14_ONE) begin
        v = Q14_ONE;
      end
      tab[k] = SINE_VAL_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: src/svpwm_sincos.sv
// command clamp, table index and sine/cosine lookup stages
module svpwm_sincos import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic        [15:0] angle_i,
  input  logic signed [15:0] volt_d_i,
  input  logic signed [15:0] volt_q_i,
  output svpwm_trig_t        trig_o
);

  localparam int PROD_W = 14 + SINE_IDX_W;
  localparam logic signed [15:0] CMD_MAX = 16'sd16384;
  localparam logic signed [15:0] CMD_MIN = -16'sd16384;

  logic                  s1_valid_q;
  logic            [1:0] s1_quad_q;
  logic [SINE_IDX_W-1:0] s1_idx_q, s1_idx_d;
  logic signed    [15:0] s1_d_q, s1_d_d;
  logic signed    [15:0] s1_q_q, s1_q_d;
  logic     [PROD_W-1:0] idx_prod;

  logic                  s2_valid_q;
  logic signed    [15:0] s2_sin_q, s2_sin_d;
  logic signed    [15:0] s2_cos_q, s2_cos_d;
  logic signed    [15:0] s2_d_q;
  logic signed    [15:0] s2_q_q;

  logic [SINE_VAL_W-1:0] tab_fwd;
  logic [SINE_VAL_W-1:0] tab_rev;
  logic [SINE_VAL_W-1:0] sin_mag;
  logic [SINE_VAL_W-1:0] cos_mag;
  logic            [1:0] cos_quad;

  function automatic logic signed [15:0] clamp_cmd(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > CMD_MAX) begin
      r = CMD_MAX;
    end else if (v < CMD_MIN) begin
      r = CMD_MIN;
    end
    return r;
  endfunction

  always_comb begin
    idx_prod = PROD_W'(angle_i[13:0]) * PROD_W'(SINE_TABLE_ENTRIES);
    s1_idx_d = idx_prod[PROD_W-1:14];
    s1_d_d   = clamp_cmd(volt_d_i);
    s1_q_d   = clamp_cmd(volt_q_i);
  end

  always_comb begin
    tab_fwd  = SINE_TAB[s1_idx_q];
    tab_rev  = SINE_TAB[SINE_IDX_W'(SINE_TABLE_ENTRIES) - s1_idx_q];
    cos_quad = s1_quad_q + 2'd1;
    sin_mag  = s1_quad_q[0] ? tab_rev : tab_fwd;
    cos_mag  = cos_quad[0] ? tab_rev : tab_fwd;
    s2_sin_d = s1_quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    s2_cos_d = cos_quad[1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_quad_q <= angle_i[15:14];
    s1_idx_q  <= s1_idx_d;
    s1_d_q    <= s1_d_d;
    s1_q_q    <= s1_q_d;
    s2_sin_q  <= s2_sin_d;
    s2_cos_q  <= s2_cos_d;
    s2_d_q    <= s1_d_q;
    s2_q_q    <= s1_q_q;
  end

  assign trig_o = '{valid: s2_valid_q, sin: s2_sin_q, cos: s2_cos_q, d: s2_d_q, q: s2_q_q};

endmodule

// File: src/svpwm_park_clarke.sv
// inverse park and inverse clarke stages
module svpwm_park_clarke import svpwm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  svpwm_trig_t  trig_i,
  output svpwm_phase_t phase_o
);

  localparam logic signed [17:0] HALF_SQRT3 = 18'sd56756;

  logic               s3_valid_q;
  logic signed [29:0] s3_dc_q, s3_qs_q, s3_ds_q, s3_qc_q;
  logic signed [31:0] dc_full, qs_full, ds_full, qc_full;

  logic               s4_valid_q;
  logic signed [30:0] s4_alpha_q, s4_alpha_d;
  logic signed [30:0] s4_beta_q, s4_beta_d;

  logic               s5_valid_q;
  logic signed [30:0] s5_alpha_q;
  logic signed [47:0] s5_hb_q, s5_hb_d;

  logic               s6_valid_q;
  logic signed [47:0] s6_ua_q, s6_ua_d;
  logic signed [47:0] s6_ub_q, s6_ub_d;
  logic signed [47:0] s6_uc_q, s6_uc_d;
  logic signed [47:0] half_alpha;

  always_comb begin
    dc_full = trig_i.d * trig_i.cos;
    qs_full = trig_i.q * trig_i.sin;
    ds_full = trig_i.d * trig_i.sin;
    qc_full = trig_i.q * trig_i.cos;
  end

  always_comb begin
    s4_alpha_d = 31'(s3_dc_q) - 31'(s3_qs_q);
    s4_beta_d  = 31'(s3_ds_q) + 31'(s3_qc_q);
    s5_hb_d    = 48'(s4_beta_q) * 48'(HALF_SQRT3);
  end

  always_comb begin
    half_alpha = 48'(s5_alpha_q) <<< 15;
    s6_ua_d    = 48'(s5_alpha_q) <<< 16;
    s6_ub_d    = s5_hb_q - half_alpha;
    s6_uc_d    = -half_alpha - s5_hb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= trig_i.valid;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_dc_q    <= dc_full[29:0];
    s3_qs_q    <= qs_full[29:0];
    s3_ds_q    <= ds_full[29:0];
    s3_qc_q    <= qc_full[29:0];
    s4_alpha_q <= s4_alpha_d;
    s4_beta_q  <= s4_beta_d;
    s5_alpha_q <= s4_alpha_q;
    s5_hb_q    <= s5_hb_d;
    s6_ua_q    <= s6_ua_d;
    s6_ub_q    <= s6_ub_d;
    s6_uc_q    <= s6_uc_d;
  end

  assign phase_o = '{valid: s6_valid_q, ua: s6_ua_q, ub: s6_ub_q, uc: s6_uc_q};

endmodule

// File: src/svpwm_duty.sv
// zero sequence injection, rounding and duty saturation stages
module svpwm_duty import svpwm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  svpwm_phase_t phase_i,
  output logic         valid_o,
  output logic  [15:0] duty_u_o,
  output logic  [15:0] duty_v_o,
  output logic  [15:0] duty_w_o,
  output logic         saturated_o
);

  localparam logic signed [51:0] DUTY_BIAS = (52'sd1 <<< 44) + (52'sd1 <<< 28);

  typedef struct packed {
    logic [15:0] duty;
    logic        sat;
  } duty_res_t;

  logic               s7_valid_q;
  logic signed [47:0] s7_ua_q, s7_ub_q, s7_uc_q;
  logic signed [48:0] s7_sum_q, s7_sum_d;
  logic signed [47:0] mx, mn;

  logic               s8_valid_q;
  logic        [15:0] s8_u_q, s8_v_q, s8_w_q;
  logic               s8_sat_q, s8_sat_d;
  duty_res_t          res_u, res_v, res_w;

  function automatic duty_res_t make_duty(input logic signed [47:0] u,
                                          input logic signed [48:0] sum);
    logic signed [51:0] r;
    duty_res_t          res;
    r = (52'(u) <<< 1) - 52'(sum) + DUTY_BIAS;
    res.sat = 1'b0;
    if (r[51]) begin
      res.duty = '0;
      res.sat  = 1'b1;
    end else if (|r[50:45]) begin
      res.duty = '1;
      res.sat  = 1'b1;
    end else begin
      res.duty = r[44:29];
    end
    return res;
  endfunction

  always_comb begin
    mx = phase_i.ua;
    mn = phase_i.ua;
    if (phase_i.ub > mx) begin
      mx = phase_i.ub;
    end
    if (phase_i.uc > mx) begin
      mx = phase_i.uc;
    end
    if (phase_i.ub < mn) begin
      mn = phase_i.ub;
    end
    if (phase_i.uc < mn) begin
      mn = phase_i.uc;
    end
    s7_sum_d = 49'(mx) + 49'(mn);
  end

  always_comb begin
    res_u    = make_duty(s7_ua_q, s7_sum_q);
    res_v    = make_duty(s7_ub_q, s7_sum_q);
    res_w    = make_duty(s7_uc_q, s7_sum_q);
    s8_sat_d = res_u.sat | res_v.sat | res_w.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
    end else begin
      s7_valid_q <= phase_i.valid;
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_ua_q  <= phase_i.ua;
    s7_ub_q  <= phase_i.ub;
    s7_uc_q  <= phase_i.uc;
    s7_sum_q <= s7_sum_d;
    s8_u_q   <= res_u.duty;
    s8_v_q   <= res_v.duty;
    s8_w_q   <= res_w.duty;
    s8_sat_q <= s8_sat_d;
  end

  assign valid_o     = s8_valid_q;
  assign duty_u_o    = s8_u_q;
  assign duty_v_o    = s8_v_q;
  assign duty_w_o    = s8_w_q;
  assign saturated_o = s8_sat_q;

endmodule

// File: src/space_vector_pwm_modulator.sv
// space vector pwm modulator top level
// A command word (angle, d and q voltage) is taken on every clock edge where start is
// high; busy stays low, so a new word may follow in every cycle. Each word gives one
// result, shown for exactly one cycle with done_o high, with the three Q0.16 phase
// duties and a flag that is set when any duty was clipped to 0..1.
// Each word passes through eight register stages: clamp and table index, sine and
// cosine lookup, the four Park products, the alpha/beta sums, the sqrt(3)/2 product,
// the Clarke phases, the max plus min of the phases, and rounding with saturation.
// There is no backpressure: the receiver must take each result as it appears.
module space_vector_pwm_modulator import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic        [15:0] angle_i,
  input  logic signed [15:0] volt_d_i,
  input  logic signed [15:0] volt_q_i,
  output logic               done_o,
  output logic        [15:0] duty_u_o,
  output logic        [15:0] duty_v_o,
  output logic        [15:0] duty_w_o,
  output logic               saturated_o
);

  svpwm_trig_t  trig;
  svpwm_phase_t phase;
  logic         accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  svpwm_sincos u_sincos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .angle_i  (angle_i),
    .volt_d_i (volt_d_i),
    .volt_q_i (volt_q_i),
    .trig_o   (trig)
  );

  svpwm_park_clarke u_park_clarke (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .trig_i  (trig),
    .phase_o (phase)
  );

  svpwm_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .phase_i     (phase),
    .valid_o     (done_o),
    .duty_u_o    (duty_u_o),
    .duty_v_o    (duty_v_o),
    .duty_w_o    (duty_w_o),
    .saturated_o (saturated_o)
  );

endmodule

// File: src/svpwm_checker.sv
// port-level checker for the space vector pwm modulator, bound to the top level
`include "space_vector_pwm_modulator_defines.svh"

module svpwm_checker import svpwm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic        [15:0] angle_i,
  input logic signed [15:0] volt_d_i,
  input logic signed [15:0] volt_q_i,
  input logic               done_o,
  input logic        [15:0] duty_u_o,
  input logic        [15:0] duty_v_o,
  input logic        [15:0] duty_w_o,
  input logic               saturated_o
);

  `SVPWM_ASSERT(done_has_word, done_o, $past(start && !busy, SVPWM_LATENCY), "result without a word")

  `SVPWM_ASSERT_NEXT(word_gives_done, start && !busy, ##(SVPWM_LATENCY-1) done_o, "word lost")

  `SVPWM_ASSERT(zero_cmd_mid, done_o && $past(start && !busy && volt_d_i == 16'sd0 && volt_q_i == 16'sd0, SVPWM_LATENCY), duty_u_o == 16'd32768 && duty_v_o == 16'd32768 && duty_w_o == 16'd32768 && !saturated_o, "zero command not centered")

endmodule

bind space_vector_pwm_modulator svpwm_checker u_checker (.*);
